[src/hse_pkg.sv]
// Shared types, constants and the quarter-wave sine and cosine tables of the series evaluator.
`default_nettype none

package hse_pkg;

    // Sizing of the series and of the phase lookup.
    localparam int NH         = 7;
    localparam int PHASE_BITS = 10;
    localparam int QB         = PHASE_BITS - 2;
    localparam int QUARTER    = 1 << QB;

    // The coefficient table has sixteen slots, so at most seven harmonic pairs exist.
    localparam int H_MAX      = (NH < 7) ? NH : 7;

    localparam int COEF_W     = 32;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W      = 4;
    localparam int ROWS       = TABLE_DEPTH / 2;
    localparam int ROW_W      = 3;
    localparam int CNT_W      = 4;

    localparam int MAG_W      = 17;
    localparam int TRIG_W     = 18;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 52;
    localparam int TAU_W      = 48;
    localparam int DIFF_W     = 33;
    localparam int SLOPE_W    = 66;
    localparam int WIDE_W     = 68;
    localparam int OUT_W      = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int HARM_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_T_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARMONICS = 2'd2;

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                     mode;
        logic [IDX_W-1:0]         coeff_index;
        logic signed [COEF_W-1:0] coeff_value;
        logic signed [31:0]       time_value;
    } hse_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] series_value;
        logic                    saturated;
    } hse_out_t;

    // Coefficient write request from the sequencer to the table.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     index;
        logic [COEF_W-1:0]    value;
    } hse_wr_t;

    // Operands of the two multiplier lanes.
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a0;
        logic signed [MUL_B_W-1:0] b0;
        logic signed [MUL_A_W-1:0] a1;
        logic signed [MUL_B_W-1:0] b1;
    } hse_mac_op_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } hse_trig_t;

    typedef logic [QUARTER-1:0][MAG_W-1:0] quarter_tab_t;

    // Magnitudes over one quadrant in Q16, from truncated Taylor series evaluated in Q30.
    function automatic quarter_tab_t build_quarter(input logic want_cos);
        quarter_tab_t tab;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  t;
        logic [63:0]  half;
        logic [63:0]  m;
        tab = '0;
        for (int r = 0; r < QUARTER; r++) begin
            x  = (64'(r) * HALF_PI_Q30) >> QB;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            if (!want_cos) begin
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
                m = (x * t) >> 30;
            end
            else begin
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
                t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
                half = ((x2 * t) >> 30) / 64'd2;
                m = (half > Q30_ONE) ? 64'd0 : (Q30_ONE - half);
            end
            tab[r] = MAG_W'((m + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam quarter_tab_t SIN_Q = build_quarter(1'b0);
    localparam quarter_tab_t COS_Q = build_quarter(1'b1);

endpackage

`default_nettype wire

[src/harmonic_series_evaluator.sv]
// Top level: sequencer, accumulators and ports of the harmonic series evaluator.
//
// Input items arrive on in_valid/in_stall/in_data; a transfer happens when in_valid is high
// and in_stall is low. A load item (mode 0) writes one Q16.16 coefficient and completes with
// no result. An evaluate item (mode 1) normalizes its time, then sums offset, trend and H
// harmonic pairs, H = min(harmonics_in_use, 7), and returns one result.
// An evaluate item keeps the input stalled until the sequencer is back in idle: ST_TAU and
// ST_TSUM form the normalization product, ST_SL0 fetches the trend operands, then harmonic
// pairs issue one per cycle through the shared two-lane multiplier and drain, the first two
// issue cycles also finishing the trend term, then ST_FIN sees the pipeline empty and loads
// the output. The next item is taken once the sequencer is back in idle.
// The result appears in out_data with out_valid in the cycle after the sequencer finishes.
// Results leave through an output register, so new items are taken while a result waits.
// If the receiver stalls, the result holds; a following evaluation finishes its sum and
// then waits until the output register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the clock edge and
// belong to idle periods. Reset clears all coefficients to zero, sets t_min and inv_span to
// zero and harmonics_in_use to one; no clearing pass is needed.
`default_nettype none

module harmonic_series_evaluator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire hse_pkg::hse_in_t                     in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output hse_pkg::hse_out_t                         out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [hse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hse_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TAU  = 8'b0000_0010,
        ST_TSUM = 8'b0000_0100,
        ST_SL0  = 8'b0000_1000,
        ST_SL1  = 8'b0001_0000,
        ST_SL2  = 8'b0010_0000,
        ST_HARM = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0]                  t_min_reg, t_min_next;
    logic [31:0]                         inv_span_reg, inv_span_next;
    logic [hse_pkg::HARM_W-1:0]          harm_reg, harm_next;

    logic signed [hse_pkg::DIFF_W-1:0]   d_reg, d_next;
    logic [hse_pkg::TAU_W-1:0]           tau_reg, tau_next;
    logic [hse_pkg::SLOPE_W-1:0]         slope_reg, slope_next;
    logic [hse_pkg::ACC_W-1:0]           acc_reg, acc_next;
    logic [31:0]                         phase_reg, phase_next;
    logic [hse_pkg::CNT_W-1:0]           issue_j_reg, issue_j_next;
    logic                                tv_a_reg, tv_a_next;
    logic                                tv_b_reg, tv_b_next;
    logic                                out_valid_reg, out_valid_next;
    hse_pkg::hse_out_t                   out_data_reg, out_data_next;

    hse_pkg::hse_wr_t                    wr;
    hse_pkg::hse_mac_op_t                op;
    hse_pkg::hse_trig_t                  trig;
    logic [hse_pkg::ROW_W-1:0]           rd_row;
    logic signed [hse_pkg::COEF_W-1:0]   rd_even;
    logic signed [hse_pkg::COEF_W-1:0]   rd_odd;
    logic signed [hse_pkg::PROD_W-1:0]   prod0;
    logic signed [hse_pkg::PROD_W-1:0]   prod1;

    logic [hse_pkg::HARM_W-1:0]          h_eff;
    logic                                issue_act;
    logic                                in_xfer;
    logic [hse_pkg::WIDE_W-1:0]          tau_wide;
    logic [hse_pkg::PROD_W-1:0]          rnd0;
    logic [hse_pkg::PROD_W-1:0]          rnd1;
    logic                                fin_load;

    hse_coef_mem u_coef_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_row  (rd_row),
        .rd_even (rd_even),
        .rd_odd  (rd_odd)
    );

    hse_trig u_trig (
        .clk   (clk),
        .phase (phase_reg),
        .trig  (trig)
    );

    hse_mac u_mac (
        .clk   (clk),
        .op    (op),
        .prod0 (prod0),
        .prod1 (prod1)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign h_eff = (harm_reg > hse_pkg::HARM_W'(hse_pkg::H_MAX)) ?
                   hse_pkg::HARM_W'(hse_pkg::H_MAX) : harm_reg;
    assign issue_act = ((state_reg == ST_SL1) || (state_reg == ST_SL2) ||
                        (state_reg == ST_HARM)) && (issue_j_reg <= {1'b0, h_eff});
    assign rd_row = issue_act ? issue_j_reg[hse_pkg::ROW_W-1:0] : '0;
    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        wr.en    = in_xfer && (in_data.mode == hse_pkg::MODE_LOAD);
        wr.index = in_data.coeff_index;
        wr.value = in_data.coeff_value;
    end

    // Operand selection for the shared multiplier. A harmonic in its multiply stage has priority;
    // the setup states never overlap with one.
    always_comb
    begin
        op = '0;
        if (tv_a_reg)
        begin
            op.a0 = {{2{rd_even[31]}}, rd_even};
            op.b0 = trig.cos_v;
            op.a1 = {{2{rd_odd[31]}}, rd_odd};
            op.b1 = trig.sin_v;
        end
        else
        begin
            case (state_reg)
                ST_TAU:
                begin
                    op.a0 = {d_reg[hse_pkg::DIFF_W-1], d_reg};
                    op.b0 = {2'b00, inv_span_reg[15:0]};
                    op.a1 = {d_reg[hse_pkg::DIFF_W-1], d_reg};
                    op.b1 = {2'b00, inv_span_reg[31:16]};
                end
                ST_SL0:
                begin
                    op.a0 = {{2{rd_odd[31]}}, rd_odd};
                    op.b0 = {2'b00, tau_reg[15:0]};
                    op.a1 = {{2{rd_odd[31]}}, rd_odd};
                    op.b1 = {2'b00, tau_reg[31:16]};
                end
                ST_SL1:
                begin
                    op.a0 = {{2{rd_odd[31]}}, rd_odd};
                    op.b0 = {{2{tau_reg[47]}}, tau_reg[47:32]};
                end
                default:
                begin
                    op = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        tau_wide = {{16{prod0[hse_pkg::PROD_W-1]}}, prod0} + {prod1, 16'b0};
        // Each harmonic term is rounded half up to Q16 on its own before it joins the sum.
        rnd0 = prod0 + hse_pkg::PROD_W'(32768);
        rnd1 = prod1 + hse_pkg::PROD_W'(32768);
    end

    always_comb
    begin
        state_next     = state_reg;
        t_min_next     = t_min_reg;
        inv_span_next  = inv_span_reg;
        harm_next      = harm_reg;
        d_next         = d_reg;
        tau_next       = tau_reg;
        slope_next     = slope_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        issue_j_next   = issue_j_reg;
        tv_a_next      = issue_act;
        tv_b_next      = tv_a_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                hse_pkg::CFG_T_MIN:     t_min_next    = cfg_data;
                hse_pkg::CFG_INV_SPAN:  inv_span_next = cfg_data;
                hse_pkg::CFG_HARMONICS: harm_next     = cfg_data[hse_pkg::HARM_W-1:0];
                default:                t_min_next    = t_min_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (issue_act)
        begin
            issue_j_next = issue_j_reg + hse_pkg::CNT_W'(1);
            phase_next   = phase_reg + tau_reg[31:0];
        end

        if (tv_b_reg)
        begin
            acc_next = acc_reg + {{16{rnd0[hse_pkg::PROD_W-1]}}, rnd0[hse_pkg::PROD_W-1:16]}
                               + {{16{rnd1[hse_pkg::PROD_W-1]}}, rnd1[hse_pkg::PROD_W-1:16]};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (in_data.mode == hse_pkg::MODE_EVAL))
                begin
                    d_next = {in_data.time_value[31], in_data.time_value}
                           - {t_min_reg[31], t_min_reg};
                    state_next = ST_TAU;
                end
            end
            ST_TAU:
            begin
                state_next = ST_TSUM;
            end
            ST_TSUM:
            begin
                // Clamp the normalized time to the Q16.32 range.
                if (tau_wide[hse_pkg::WIDE_W-1:47] == {21{tau_wide[47]}})
                begin
                    tau_next = tau_wide[hse_pkg::TAU_W-1:0];
                end
                else if (tau_wide[hse_pkg::WIDE_W-1])
                begin
                    tau_next = {1'b1, 47'b0};
                end
                else
                begin
                    tau_next = {1'b0, {47{1'b1}}};
                end
                state_next = ST_SL0;
            end
            ST_SL0:
            begin
                acc_next     = {{20{rd_even[31]}}, rd_even};
                phase_next   = tau_reg[31:0];
                issue_j_next = hse_pkg::CNT_W'(1);
                state_next   = ST_SL1;
            end
            ST_SL1:
            begin
                // Low two partial products of the trend term, with the rounding half added.
                slope_next = {{14{prod0[hse_pkg::PROD_W-1]}}, prod0}
                           + {prod1[49:0], 16'b0}
                           + (hse_pkg::SLOPE_W'(1) << 31);
                state_next = ST_SL2;
            end
            ST_SL2:
            begin
                // The top partial product has no fraction bits left, so it adds after the shift.
                acc_next = acc_reg + {{18{slope_reg[hse_pkg::SLOPE_W-1]}},
                                      slope_reg[hse_pkg::SLOPE_W-1:32]} + prod0;
                state_next = ST_HARM;
            end
            ST_HARM:
            begin
                if (!issue_act && !tv_a_reg && !tv_b_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_load)
                begin
                    out_valid_next = 1'b1;
                    if (acc_reg[hse_pkg::ACC_W-1:47] == {5{acc_reg[47]}})
                    begin
                        out_data_next.series_value = acc_reg[hse_pkg::OUT_W-1:0];
                        out_data_next.saturated    = 1'b0;
                    end
                    else
                    begin
                        out_data_next.series_value = acc_reg[hse_pkg::ACC_W-1] ?
                                                     {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                        out_data_next.saturated    = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_min_reg     <= '0;
            inv_span_reg  <= '0;
            harm_reg      <= hse_pkg::HARM_W'(1);
            issue_j_reg   <= '0;
            tv_a_reg      <= 1'b0;
            tv_b_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_min_reg     <= t_min_next;
            inv_span_reg  <= inv_span_next;
            harm_reg      <= harm_next;
            issue_j_reg   <= issue_j_next;
            tv_a_reg      <= tv_a_next;
            tv_b_reg      <= tv_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        tau_reg      <= tau_next;
        slope_reg    <= slope_next;
        acc_reg      <= acc_next;
        phase_reg    <= phase_next;
        out_data_reg <= out_data_next;
    end

    // The trend term folds into the sum in a cycle where no harmonic term is added.
    a_no_fold_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SL2) |-> !tv_b_reg)
        else $error("harmonic accumulate collides with trend fold");

    // The sum is complete before it goes to the output register.
    a_drained_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (!tv_a_reg && !tv_b_reg))
        else $error("harmonic pipeline not drained at finish");

    // The harmonic counter never runs past the last pair plus one.
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HARM) |-> (issue_j_reg <= ({1'b0, h_eff} + hse_pkg::CNT_W'(1))))
        else $error("harmonic counter overran");

    // A finished result is delivered on the cycle after the output register frees up.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not loaded into output register");

endmodule

`default_nettype wire

[src/hse_coef_mem.sv]
// Coefficient table: two banks of rows for even and odd slots, with per-slot valid bits.
`default_nettype none

module hse_coef_mem (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hse_pkg::hse_wr_t                    wr,
    input  wire logic [hse_pkg::ROW_W-1:0]           rd_row,
    output logic signed [hse_pkg::COEF_W-1:0]        rd_even,
    output logic signed [hse_pkg::COEF_W-1:0]        rd_odd
);

    logic [hse_pkg::COEF_W-1:0]      mem_even [hse_pkg::ROWS];
    logic [hse_pkg::COEF_W-1:0]      mem_odd  [hse_pkg::ROWS];
    logic [hse_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [hse_pkg::COEF_W-1:0]      even_q_reg;
    logic [hse_pkg::COEF_W-1:0]      odd_q_reg;
    logic                            even_ok_reg;
    logic                            odd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.index[0])
            begin
                mem_odd[wr.index[hse_pkg::IDX_W-1:1]] <= wr.value;
            end
            else
            begin
                mem_even[wr.index[hse_pkg::IDX_W-1:1]] <= wr.value;
            end
        end
        even_q_reg <= mem_even[rd_row];
        odd_q_reg  <= mem_odd[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            even_ok_reg <= 1'b0;
            odd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.index] <= 1'b1;
            end
            even_ok_reg <= valid_reg[{rd_row, 1'b0}];
            odd_ok_reg  <= valid_reg[{rd_row, 1'b1}];
        end
    end

    // A slot that was never loaded reads as zero.
    assign rd_even = even_ok_reg ? $signed(even_q_reg) : '0;
    assign rd_odd  = odd_ok_reg ? $signed(odd_q_reg) : '0;

endmodule

`default_nettype wire

[src/hse_trig.sv]
// Phase to sine and cosine lookup with quadrant folding, registered.
`default_nettype none

module hse_trig (
    input  wire logic         clk,
    input  wire logic [31:0]  phase,
    output hse_pkg::hse_trig_t trig
);

    logic [1:0]                   quad;
    logic [hse_pkg::QB-1:0]       r;
    logic [hse_pkg::MAG_W-1:0]    s_mag;
    logic [hse_pkg::MAG_W-1:0]    c_mag;
    logic [hse_pkg::MAG_W-1:0]    sin_mag;
    logic [hse_pkg::MAG_W-1:0]    cos_mag;
    logic signed [hse_pkg::TRIG_W-1:0] sin_next;
    logic signed [hse_pkg::TRIG_W-1:0] cos_next;
    hse_pkg::hse_trig_t           trig_reg;

    always_comb
    begin
        quad    = phase[31:30];
        r       = phase[29 -: hse_pkg::QB];
        s_mag   = hse_pkg::SIN_Q[r];
        c_mag   = hse_pkg::COS_Q[r];
        // Odd quadrants swap the roles of the two quarter tables.
        sin_mag = quad[0] ? c_mag : s_mag;
        cos_mag = quad[0] ? s_mag : c_mag;
        sin_next = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_next = (quad[1] ^ quad[0]) ? -$signed({1'b0, cos_mag})
                                       : $signed({1'b0, cos_mag});
    end

    always_ff @(posedge clk)
    begin
        trig_reg.sin_v <= sin_next;
        trig_reg.cos_v <= cos_next;
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

[src/hse_mac.sv]
// Shared two-lane signed multiplier with registered products.
`default_nettype none

module hse_mac (
    input  wire logic                              clk,
    input  wire hse_pkg::hse_mac_op_t              op,
    output logic signed [hse_pkg::PROD_W-1:0]      prod0,
    output logic signed [hse_pkg::PROD_W-1:0]      prod1
);

    logic signed [hse_pkg::PROD_W-1:0] prod0_reg;
    logic signed [hse_pkg::PROD_W-1:0] prod1_reg;

    always_ff @(posedge clk)
    begin
        prod0_reg <= op.a0 * op.b0;
        prod1_reg <= op.a1 * op.b1;
    end

    assign prod0 = prod0_reg;
    assign prod1 = prod1_reg;

endmodule

`default_nettype wire
